// ----- rtl/core/source_text_tokenizer_macros.svh -----
// Assertion helpers for the tokenizer checker.
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// Checked only while out of reset.
`define STT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tokenizer check failed");

// Checked at every edge, reset included.
`define STT_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("tokenizer reset check failed");

`endif

// ----- rtl/core/stt_pkg.sv -----
`timescale 1ns / 1ps

package stt_pkg;

    // token kinds
    localparam logic [4:0] KIND_SPACE  = 5'd0;
    localparam logic [4:0] KIND_ID     = 5'd1;
    localparam logic [4:0] KIND_INT    = 5'd2;
    localparam logic [4:0] KIND_OF     = 5'd3;
    localparam logic [4:0] KIND_ARROW  = 5'd4;
    localparam logic [4:0] KIND_ASSIGN = 5'd5;
    localparam logic [4:0] KIND_LPAREN = 5'd6;
    localparam logic [4:0] KIND_RPAREN = 5'd7;
    localparam logic [4:0] KIND_LBRACE = 5'd8;
    localparam logic [4:0] KIND_RBRACE = 5'd9;
    localparam logic [4:0] KIND_LBRACK = 5'd10;
    localparam logic [4:0] KIND_RBRACK = 5'd11;
    localparam logic [4:0] KIND_COLON  = 5'd12;
    localparam logic [4:0] KIND_COMMA  = 5'd13;
    localparam logic [4:0] KIND_STAR   = 5'd14;
    localparam logic [4:0] KIND_LT     = 5'd15;
    localparam logic [4:0] KIND_GT     = 5'd16;
    localparam logic [4:0] KIND_SEMI   = 5'd17;
    localparam logic [4:0] KIND_EOF    = 5'd18;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // most words one input word can produce, and output queue depth (power of two)
    localparam int MAX_RES    = 3;
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic [7:0] byte_value;
        logic [4:0] token_kind;
        logic       token_start;
        logic       bad_char;
        logic       end_of_text;
    } t_result;

    typedef struct packed {
        t_result    res;
        logic [4:0] run_kind;
    } t_label;

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h5B:   k = KIND_LBRACK;
            8'h5D:   k = KIND_RBRACK;
            8'h3A:   k = KIND_COLON;
            8'h2C:   k = KIND_COMMA;
            8'h2A:   k = KIND_STAR;
            8'h3C:   k = KIND_LT;
            8'h3E:   k = KIND_GT;
            8'h3B:   k = KIND_SEMI;
            default: k = KIND_SPACE;
        endcase
        return k;
    endfunction

    // Label byte c given lookahead nx and the running token kind.
    function automatic t_label label_byte(input logic [7:0] c, input logic [7:0] nx,
                                          input logic [4:0] run);
        t_label     l;
        logic       letter;
        logic       digit;
        logic [4:0] p;
        letter = (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
        digit  = (c inside {[8'h30:8'h39]});
        p      = punct_kind(c);
        l.res.byte_value  = c;
        l.res.token_kind  = KIND_SPACE;
        l.res.token_start = 1'b0;
        l.res.bad_char    = 1'b0;
        l.res.end_of_text = 1'b0;
        l.run_kind        = run;
        if ((run == KIND_OF || run == KIND_ARROW) && c == CH_GT) begin
            l.res.token_kind = run;
            l.run_kind       = KIND_SPACE;
        end else if (c inside {CH_SP, CH_LF, CH_CR, CH_TAB}) begin
            l.run_kind = KIND_SPACE;
        end else if (letter || digit) begin
            if (run == KIND_ID || run == KIND_INT) begin
                l.res.token_kind = run;
            end else begin
                l.res.token_kind  = letter ? KIND_ID : KIND_INT;
                l.res.token_start = 1'b1;
                l.run_kind        = letter ? KIND_ID : KIND_INT;
            end
        end else if (c == CH_UNDER) begin
            l.res.token_kind = KIND_ID;
            if (run != KIND_ID) begin
                l.res.token_start = 1'b1;
                l.run_kind        = KIND_ID;
            end
        end else if (c == CH_MINUS && nx == CH_GT) begin
            l.res.token_kind  = KIND_OF;
            l.res.token_start = 1'b1;
            l.run_kind        = KIND_OF;
        end else if (c == CH_EQ) begin
            l.res.token_start = 1'b1;
            l.res.token_kind  = (nx == CH_GT) ? KIND_ARROW : KIND_ASSIGN;
            l.run_kind        = (nx == CH_GT) ? KIND_ARROW : KIND_SPACE;
        end else if (p != KIND_SPACE) begin
            l.res.token_kind  = p;
            l.res.token_start = 1'b1;
            l.run_kind        = KIND_SPACE;
        end else begin
            l.res.bad_char = 1'b1;
            l.run_kind     = KIND_SPACE;
        end
        return l;
    endfunction

endpackage

// ----- rtl/core/source_text_tokenizer.sv -----
// Streaming source-text tokenizer.
// Input channel: i_in_valid / o_in_stall carry one text byte per word plus a
// final flag; a byte of 0 also ends the text. Output channel: o_out_valid /
// i_out_stall carry one labeled byte per word (kind, token start, bad char,
// end of text). A word is taken when valid is high and stall is low.
// One byte is held back as lookahead, so a byte is labeled when the next one
// arrives; its word is then registered into the output queue.
// An ending word labels the held byte and the last byte, then emits the
// end-of-text word: up to three output words for one input word.
// Throughput: one input word per cycle while the output side keeps up. The
// rate is set by the 4-entry output queue: input is taken while at most one
// word waits, so an ending word, worth three, holds off the next input word.
// Receiver stall: words wait in the queue; once two or more wait, o_in_stall
// rises and holds the sender. After a bad character, later bytes give no
// words until the end of text.
// Reset (i_rst_n low, synchronous) empties the queue and clears the held-byte
// flag, running token and error flag; the block is ready the next cycle.
`timescale 1ns / 1ps

module source_text_tokenizer
    import stt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_final_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_byte_value,
    output logic [4:0] o_token_kind,
    output logic       o_token_start,
    output logic       o_bad_char,
    output logic       o_end_of_text
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] STALL_LEVEL = CW'(FIFO_DEPTH - MAX_RES);

    // tokenizer state
    logic [7:0]    r_held_char;
    logic          r_held_present, n_held_present;
    logic [4:0]    r_run_kind, n_run_kind;
    logic          r_error_seen, n_error_seen;
    logic [7:0]    n_held_char;

    // output queue
    t_result       r_fifo [FIFO_DEPTH];
    t_result       n_fifo [FIFO_DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    logic          in_take, out_take, text_end;
    logic          v1, v2, err_a, err_b;
    logic [4:0]    run_a, run_b;
    t_label        lab1, lab2;
    t_result       eof_res;
    logic [1:0]    push_cnt;

    assign o_in_stall  = (r_count > STALL_LEVEL);
    assign o_out_valid = (r_count != '0);
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_take    = o_out_valid && !i_out_stall;
    assign text_end    = (i_text_byte == CH_NUL) || i_final_byte;

    assign o_byte_value  = r_fifo[r_rd_ptr].byte_value;
    assign o_token_kind  = r_fifo[r_rd_ptr].token_kind;
    assign o_token_start = r_fifo[r_rd_ptr].token_start;
    assign o_bad_char    = r_fifo[r_rd_ptr].bad_char;
    assign o_end_of_text = r_fifo[r_rd_ptr].end_of_text;

    always_comb begin
        // held byte, labeled with the incoming byte as lookahead
        lab1  = label_byte(r_held_char, i_text_byte, r_run_kind);
        v1    = !r_error_seen && r_held_present;
        err_a = r_error_seen || (v1 && lab1.res.bad_char);
        run_a = v1 ? lab1.run_kind : r_run_kind;

        // last byte of the text, labeled at once with NUL lookahead
        lab2  = label_byte(i_text_byte, CH_NUL, run_a);
        v2    = !err_a && (i_text_byte != CH_NUL) && text_end;
        err_b = err_a || (v2 && lab2.res.bad_char);
        run_b = v2 ? lab2.run_kind : run_a;

        eof_res.byte_value  = CH_NUL;
        eof_res.token_kind  = KIND_EOF;
        eof_res.token_start = 1'b1;
        eof_res.bad_char    = 1'b0;
        eof_res.end_of_text = 1'b1;

        // pack the words produced into consecutive queue slots
        n_fifo   = r_fifo;
        n_wr_ptr = r_wr_ptr;
        push_cnt = 2'd0;
        if (in_take) begin
            if (v1) begin
                n_fifo[n_wr_ptr] = lab1.res;
                n_wr_ptr         = n_wr_ptr + AW'(1);
                push_cnt         = push_cnt + 2'd1;
            end
            if (v2) begin
                n_fifo[n_wr_ptr] = lab2.res;
                n_wr_ptr         = n_wr_ptr + AW'(1);
                push_cnt         = push_cnt + 2'd1;
            end
            if (text_end) begin
                n_fifo[n_wr_ptr] = eof_res;
                n_wr_ptr         = n_wr_ptr + AW'(1);
                push_cnt         = push_cnt + 2'd1;
            end
        end

        n_rd_ptr = out_take ? r_rd_ptr + AW'(1) : r_rd_ptr;
        n_count  = r_count + CW'(push_cnt) - CW'(out_take);

        n_held_char    = r_held_char;
        n_held_present = r_held_present;
        n_run_kind     = r_run_kind;
        n_error_seen   = r_error_seen;
        if (in_take) begin
            if (text_end) begin
                // end of text returns the tokenizer state to its reset values
                n_held_char    = CH_NUL;
                n_held_present = 1'b0;
                n_run_kind     = KIND_SPACE;
                n_error_seen   = 1'b0;
            end else begin
                n_held_char    = i_text_byte;
                n_held_present = !err_b;
                n_run_kind     = run_b;
                n_error_seen   = err_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_present <= 1'b0;
            r_run_kind     <= KIND_SPACE;
            r_error_seen   <= 1'b0;
            r_wr_ptr       <= '0;
            r_rd_ptr       <= '0;
            r_count        <= '0;
        end else begin
            r_held_present <= n_held_present;
            r_run_kind     <= n_run_kind;
            r_error_seen   <= n_error_seen;
            r_wr_ptr       <= n_wr_ptr;
            r_rd_ptr       <= n_rd_ptr;
            r_count        <= n_count;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_held_char <= n_held_char;
        r_fifo      <= n_fifo;
    end

endmodule

// ----- rtl/core/stt_checker.sv -----
`timescale 1ns / 1ps
`include "source_text_tokenizer_macros.svh"

module stt_checker
    import stt_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_text_byte,
    input logic       i_final_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_byte_value,
    input logic [4:0] o_token_kind,
    input logic       o_token_start,
    input logic       o_bad_char,
    input logic       o_end_of_text
);

    // reset leaves the queue empty and the input open
    `STT_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_stall))

    // an empty queue never holds off the sender
    `STT_ASSERT(a_empty_no_stall, i_clk, i_rst_n, !o_out_valid |-> !o_in_stall)

    // an accepted end of text always leaves at least its end word queued
    `STT_ASSERT(a_end_gives_word, i_clk, i_rst_n,
        (i_in_valid && !o_in_stall && (i_text_byte == CH_NUL || i_final_byte)) |=>
        o_out_valid)

    // a stalled output word holds
    `STT_ASSERT(a_out_hold, i_clk, i_rst_n,
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_byte_value) && $stable(o_token_kind) &&
         $stable(o_token_start) && $stable(o_bad_char) && $stable(o_end_of_text)))

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);
